// ===== sv/pci_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pci_pkg: shared definitions for the polyline / circle intersection block
// Register map, datapath operand and action codes, and the command and
// status bundles exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package pci_pkg;

    // Default coordinate width (signed fixed point, 4 fraction bits)
    localparam int COORD_WIDTH_DEFAULT = 16;

    // Configuration register map
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIUS   = 2'd2;

    // Multiplier operand sources (sign-magnitude registers in the datapath)
    typedef enum logic [3:0] {
        OPD_U1,   // x1 - cx
        OPD_V1,   // y1 - cy
        OPD_U2,   // x2 - cx
        OPD_V2,   // y2 - cy
        OPD_DX,   // x2 - x1
        OPD_DY,   // y2 - y1
        OPD_R,    // radius
        OPD_C,    // stored line constant c
        OPD_AB,   // stored a^2 + b^2
        OPD_RR    // stored r^2
    } opnd_t;

    // Accumulator capture actions
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_STORE_RR,
        ACT_STORE_C,
        ACT_STORE_AB
    } act_t;

    // Controller to datapath
    typedef struct packed {
        logic  load;     // latch vertex and form differences
        logic  mul_en;   // issue one digit product
        opnd_t a_sel;
        opnd_t b_sel;
        logic  a_hi;     // use upper digit of operand a
        logic  b_hi;     // use upper digit of operand b
        logic  sub;      // subtract the product
        logic  clr;      // product replaces the accumulator
        act_t  act;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic acc_neg;
        logic acc_zero;
        logic eq_x;      // x1 == x2
        logic eq_y;      // y1 == y2
    } dp_status_t;

endpackage
`default_nettype wire

// ===== sv/pci_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pci_datapath: arithmetic for the edge / circle test
// Holds the circle registers, the previous vertex, the endpoint differences,
// one shared digit multiplier with a registered product, a signed
// accumulator and the stored intermediates c, a^2+b^2 and r^2.
// ----------------------------------------------------------------------------
module pci_datapath #(
    parameter int COORD_WIDTH = pci_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [pci_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [COORD_WIDTH-1:0]              cfg_data,
    input  logic signed [COORD_WIDTH-1:0]       vertex_x,
    input  logic signed [COORD_WIDTH-1:0]       vertex_y,
    input  pci_pkg::dp_cmd_t                    cmd,
    output pci_pkg::dp_status_t                 status
);

    localparam int W     = COORD_WIDTH;
    localparam int DIG   = W + 1;          // multiplier digit width
    localparam int MAG_W = 2 * DIG;        // two-digit operand magnitude
    localparam int ACC_W = 2 * MAG_W + 1;  // signed accumulator

    typedef struct packed {
        logic         neg;
        logic [W-1:0] mag;
    } sm_t;

    // Sign-extended difference p - q
    function automatic logic [W:0] sdiff(input logic [W-1:0] p, input logic [W-1:0] q);
        logic [W:0] r;
        r = {p[W-1], p} - {q[W-1], q};
        return r;
    endfunction

    // Two's complement to sign-magnitude; magnitude always fits W bits
    function automatic sm_t to_sm(input logic [W:0] d);
        logic [W:0] m;
        sm_t        r;
        m = d[W] ? (~d + 1'b1) : d;
        r.neg = d[W];
        r.mag = m[W-1:0];
        return r;
    endfunction

    logic [W-1:0]     cx_reg;
    logic [W-1:0]     cy_reg;
    logic [W-2:0]     r_reg;
    logic [W-1:0]     prev_x_reg;
    logic [W-1:0]     prev_y_reg;
    sm_t              u1_reg, v1_reg, u2_reg, v2_reg, dx_reg, dy_reg;
    logic             eq_x_reg, eq_y_reg;
    logic             c_neg_reg;
    logic [MAG_W-1:0] c_mag_reg;
    logic [MAG_W-1:0] ab_mag_reg;
    logic [MAG_W-1:0] rr_mag_reg;
    logic [MAG_W:0]   opa, opb;
    logic [DIG-1:0]   a_digit, b_digit;
    logic [2*DIG-1:0] mul_out;
    logic             prod_vld_reg;
    logic [2*DIG-1:0] prod_reg;
    logic             prod_neg_reg;
    logic             prod_clr_reg;
    logic [1:0]       prod_sh_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0] ext;
    logic [ACC_W-1:0] ext_sh;
    logic [ACC_W-1:0] acc_abs;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            r_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pci_pkg::REG_CENTER_X: cx_reg <= cfg_data;
                pci_pkg::REG_CENTER_Y: cy_reg <= cfg_data;
                pci_pkg::REG_RADIUS:   r_reg  <= cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    // Previous vertex
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
        end
        else if (cmd.load)
        begin
            prev_x_reg <= vertex_x;
            prev_y_reg <= vertex_y;
        end
    end

    // Endpoint differences, formed as the transaction is taken
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            u1_reg   <= to_sm(sdiff(prev_x_reg, cx_reg));
            v1_reg   <= to_sm(sdiff(prev_y_reg, cy_reg));
            u2_reg   <= to_sm(sdiff(vertex_x, cx_reg));
            v2_reg   <= to_sm(sdiff(vertex_y, cy_reg));
            dx_reg   <= to_sm(sdiff(vertex_x, prev_x_reg));
            dy_reg   <= to_sm(sdiff(vertex_y, prev_y_reg));
            eq_x_reg <= (vertex_x == prev_x_reg);
            eq_y_reg <= (vertex_y == prev_y_reg);
        end
    end

    // Operand selection: {sign, magnitude}
    function automatic logic [MAG_W:0] pick(input pci_pkg::opnd_t s);
        logic [MAG_W:0] r;
        case (s)
            pci_pkg::OPD_U1: r = {u1_reg.neg, MAG_W'(u1_reg.mag)};
            pci_pkg::OPD_V1: r = {v1_reg.neg, MAG_W'(v1_reg.mag)};
            pci_pkg::OPD_U2: r = {u2_reg.neg, MAG_W'(u2_reg.mag)};
            pci_pkg::OPD_V2: r = {v2_reg.neg, MAG_W'(v2_reg.mag)};
            pci_pkg::OPD_DX: r = {dx_reg.neg, MAG_W'(dx_reg.mag)};
            pci_pkg::OPD_DY: r = {dy_reg.neg, MAG_W'(dy_reg.mag)};
            pci_pkg::OPD_R:  r = {1'b0, MAG_W'(r_reg)};
            pci_pkg::OPD_C:  r = {c_neg_reg, c_mag_reg};
            pci_pkg::OPD_AB: r = {1'b0, ab_mag_reg};
            pci_pkg::OPD_RR: r = {1'b0, rr_mag_reg};
            default:         r = '0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        opa     = pick(cmd.a_sel);
        opb     = pick(cmd.b_sel);
        a_digit = cmd.a_hi ? opa[MAG_W-1:DIG] : opa[DIG-1:0];
        b_digit = cmd.b_hi ? opb[MAG_W-1:DIG] : opb[DIG-1:0];
    end

    // Shared digit multiplier
    assign mul_out = a_digit * b_digit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_vld_reg <= 1'b0;
        else
            prod_vld_reg <= cmd.mul_en;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg     <= mul_out;
            prod_neg_reg <= opa[MAG_W] ^ opb[MAG_W] ^ cmd.sub;
            prod_clr_reg <= cmd.clr;
            prod_sh_reg  <= {1'b0, cmd.a_hi} + {1'b0, cmd.b_hi};
        end
    end

    // Align the product by its digit position and accumulate
    always_comb
    begin
        ext = ACC_W'(prod_reg);
        case (prod_sh_reg)
            2'd1:    ext_sh = ext << DIG;
            2'd2:    ext_sh = ext << (2 * DIG);
            default: ext_sh = ext;
        endcase
        acc_next = (prod_clr_reg ? '0 : acc_reg)
                 + (prod_neg_reg ? (~ext_sh + 1'b1) : ext_sh);
        acc_abs  = acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (prod_vld_reg)
            acc_reg <= acc_next;
    end

    // Intermediate stores taken from the accumulator
    always_ff @(posedge clk)
    begin
        case (cmd.act)
            pci_pkg::ACT_STORE_RR: rr_mag_reg <= acc_abs[MAG_W-1:0];
            pci_pkg::ACT_STORE_C:
            begin
                c_neg_reg <= acc_reg[ACC_W-1];
                c_mag_reg <= acc_abs[MAG_W-1:0];
            end
            pci_pkg::ACT_STORE_AB: ab_mag_reg <= acc_abs[MAG_W-1:0];
            default: ;
        endcase
    end

    assign status.acc_neg  = acc_reg[ACC_W-1];
    assign status.acc_zero = (acc_reg == '0);
    assign status.eq_x     = eq_x_reg;
    assign status.eq_y     = eq_y_reg;

endmodule
`default_nettype wire

// ===== sv/pci_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pci_ctrl: sequencer for the polyline / circle intersection block
// Takes vertex transactions, steps the datapath through the products of
// one edge test, keeps the polygon state and holds the result register.
// ----------------------------------------------------------------------------
module pci_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 first_vertex,
    input  logic                 last_vertex,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 intersects,
    output pci_pkg::dp_cmd_t     cmd,
    input  pci_pkg::dp_status_t  status
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_RR,  S_D1A, S_D1B, S_D1C,
        S_D2A, S_D2B, S_D2C, S_D2W, S_K2,
        S_LA,  S_LB,  S_LW,  S_LK,
        S_GA,  S_GB,  S_GC,  S_GD,  S_GE, S_GF,
        S_QC,  S_QW,  S_QK,
        S_DA,  S_DB,  S_DC,  S_DD,  S_DE, S_DF,
        S_EMIT
    } state_t;

    state_t     state_reg;
    logic       have_prev_reg;
    logic       hit_reg;
    logic       last_reg;
    logic       k1_neg_reg;
    logic       k1_zero_reg;
    logic [2:0] q_reg;
    logic       out_valid_reg;
    logic       intersects_reg;
    logic       accept;
    logic       hp_eff;
    logic       hit_eff;
    logic       acc_pos;
    logic       ends_cross;
    logic       both_in;
    state_t     state_done;

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign intersects = intersects_reg;

    // Edge state after a possible new-polygon clear
    assign hp_eff  = have_prev_reg && !first_vertex;
    assign hit_eff = hit_reg && !first_vertex;

    // Decisions on the accumulator and on the two endpoint tests
    assign acc_pos    = !status.acc_neg && !status.acc_zero;
    assign ends_cross = k1_zero_reg || status.acc_zero || (k1_neg_reg != status.acc_neg);
    assign both_in    = k1_neg_reg && status.acc_neg;
    assign state_done = last_reg ? S_EMIT : S_IDLE;

    // Command decode
    always_comb
    begin
        cmd.load   = accept;
        cmd.mul_en = 1'b0;
        cmd.a_sel  = pci_pkg::OPD_U1;
        cmd.b_sel  = pci_pkg::OPD_U1;
        cmd.a_hi   = 1'b0;
        cmd.b_hi   = 1'b0;
        cmd.sub    = 1'b0;
        cmd.clr    = 1'b0;
        cmd.act    = pci_pkg::ACT_NONE;
        case (state_reg)
            // r^2, then d1 - r^2, then d2 - r^2
            S_RR:
            begin
                cmd.mul_en = 1'b1; cmd.clr = 1'b1;
                cmd.a_sel = pci_pkg::OPD_R; cmd.b_sel = pci_pkg::OPD_R;
            end
            S_D1A:
            begin
                cmd.mul_en = 1'b1; cmd.clr = 1'b1;
                cmd.a_sel = pci_pkg::OPD_U1; cmd.b_sel = pci_pkg::OPD_U1;
            end
            S_D1B:
            begin
                cmd.mul_en = 1'b1; cmd.act = pci_pkg::ACT_STORE_RR;
                cmd.a_sel = pci_pkg::OPD_V1; cmd.b_sel = pci_pkg::OPD_V1;
            end
            S_D1C:
            begin
                cmd.mul_en = 1'b1; cmd.sub = 1'b1;
                cmd.a_sel = pci_pkg::OPD_R; cmd.b_sel = pci_pkg::OPD_R;
            end
            S_D2A:
            begin
                cmd.mul_en = 1'b1; cmd.clr = 1'b1;
                cmd.a_sel = pci_pkg::OPD_U2; cmd.b_sel = pci_pkg::OPD_U2;
            end
            S_D2B:
            begin
                cmd.mul_en = 1'b1;
                cmd.a_sel = pci_pkg::OPD_V2; cmd.b_sel = pci_pkg::OPD_V2;
            end
            S_D2C:
            begin
                cmd.mul_en = 1'b1; cmd.sub = 1'b1;
                cmd.a_sel = pci_pkg::OPD_R; cmd.b_sel = pci_pkg::OPD_R;
            end
            // axis-aligned line: offset^2 - r^2
            S_LA:
            begin
                cmd.mul_en = 1'b1; cmd.clr = 1'b1;
                cmd.a_sel = status.eq_x ? pci_pkg::OPD_U1 : pci_pkg::OPD_V1;
                cmd.b_sel = status.eq_x ? pci_pkg::OPD_U1 : pci_pkg::OPD_V1;
            end
            S_LB:
            begin
                cmd.mul_en = 1'b1; cmd.sub = 1'b1;
                cmd.a_sel = pci_pkg::OPD_R; cmd.b_sel = pci_pkg::OPD_R;
            end
            // general line: c = u1*v2 - v1*u2, a^2 + b^2 = dx^2 + dy^2
            S_GA:
            begin
                cmd.mul_en = 1'b1; cmd.clr = 1'b1;
                cmd.a_sel = pci_pkg::OPD_U1; cmd.b_sel = pci_pkg::OPD_V2;
            end
            S_GB:
            begin
                cmd.mul_en = 1'b1; cmd.sub = 1'b1;
                cmd.a_sel = pci_pkg::OPD_V1; cmd.b_sel = pci_pkg::OPD_U2;
            end
            S_GC:
            begin
                cmd.mul_en = 1'b1; cmd.clr = 1'b1;
                cmd.a_sel = pci_pkg::OPD_DX; cmd.b_sel = pci_pkg::OPD_DX;
            end
            S_GD:
            begin
                cmd.mul_en = 1'b1; cmd.act = pci_pkg::ACT_STORE_C;
                cmd.a_sel = pci_pkg::OPD_DY; cmd.b_sel = pci_pkg::OPD_DY;
            end
            S_GF:
                cmd.act = pci_pkg::ACT_STORE_AB;
            // c*c - ab*rr over digit pairs
            S_QC:
            begin
                cmd.mul_en = 1'b1;
                cmd.clr    = (q_reg == 3'd0);
                cmd.sub    = q_reg[2];
                cmd.a_hi   = q_reg[1];
                cmd.b_hi   = q_reg[0];
                cmd.a_sel  = q_reg[2] ? pci_pkg::OPD_AB : pci_pkg::OPD_C;
                cmd.b_sel  = q_reg[2] ? pci_pkg::OPD_RR : pci_pkg::OPD_C;
            end
            // projection: u1*dx + v1*dy < 0 and u2*dx + v2*dy > 0
            S_DA:
            begin
                cmd.mul_en = 1'b1; cmd.clr = 1'b1;
                cmd.a_sel = pci_pkg::OPD_U1; cmd.b_sel = pci_pkg::OPD_DX;
            end
            S_DB:
            begin
                cmd.mul_en = 1'b1;
                cmd.a_sel = pci_pkg::OPD_V1; cmd.b_sel = pci_pkg::OPD_DY;
            end
            S_DC:
            begin
                cmd.mul_en = 1'b1; cmd.clr = 1'b1;
                cmd.a_sel = pci_pkg::OPD_U2; cmd.b_sel = pci_pkg::OPD_DX;
            end
            S_DD:
            begin
                cmd.mul_en = 1'b1;
                cmd.a_sel = pci_pkg::OPD_V2; cmd.b_sel = pci_pkg::OPD_DY;
            end
            default: ;
        endcase
    end

    // State, polygon state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            have_prev_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            last_reg       <= 1'b0;
            k1_neg_reg     <= 1'b0;
            k1_zero_reg    <= 1'b0;
            q_reg          <= '0;
            out_valid_reg  <= 1'b0;
            intersects_reg <= 1'b0;
        end
        else
        begin
            // S_EMIT reloads the result register on its own
            if (out_valid_reg && out_ready && state_reg != S_EMIT)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        have_prev_reg <= 1'b1;
                        hit_reg       <= hit_eff;
                        last_reg      <= last_vertex;
                        if (hp_eff && !hit_eff)
                            state_reg <= S_RR;
                        else if (last_vertex)
                            state_reg <= S_EMIT;
                    end
                end
                S_RR:  state_reg <= S_D1A;
                S_D1A: state_reg <= S_D1B;
                S_D1B: state_reg <= S_D1C;
                S_D1C: state_reg <= S_D2A;
                S_D2A: state_reg <= S_D2B;
                S_D2B:
                begin
                    k1_neg_reg  <= status.acc_neg;
                    k1_zero_reg <= status.acc_zero;
                    state_reg   <= S_D2C;
                end
                S_D2C: state_reg <= S_D2W;
                S_D2W: state_reg <= S_K2;
                S_K2:
                begin
                    if (ends_cross)
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= state_done;
                    end
                    else if (both_in)
                    begin
                        hit_reg   <= 1'b0;
                        state_reg <= state_done;
                    end
                    else if (status.eq_x || status.eq_y)
                        state_reg <= S_LA;
                    else
                        state_reg <= S_GA;
                end
                S_LA: state_reg <= S_LB;
                S_LB: state_reg <= S_LW;
                S_LW: state_reg <= S_LK;
                S_LK:
                begin
                    if (acc_pos)
                    begin
                        hit_reg   <= 1'b0;
                        state_reg <= state_done;
                    end
                    else
                        state_reg <= S_DA;
                end
                S_GA: state_reg <= S_GB;
                S_GB: state_reg <= S_GC;
                S_GC: state_reg <= S_GD;
                S_GD: state_reg <= S_GE;
                S_GE: state_reg <= S_GF;
                S_GF:
                begin
                    q_reg     <= '0;
                    state_reg <= S_QC;
                end
                S_QC:
                begin
                    q_reg <= q_reg + 3'd1;
                    if (q_reg == 3'd7)
                        state_reg <= S_QW;
                end
                S_QW: state_reg <= S_QK;
                S_QK:
                begin
                    if (acc_pos)
                    begin
                        hit_reg   <= 1'b0;
                        state_reg <= state_done;
                    end
                    else
                        state_reg <= S_DA;
                end
                S_DA: state_reg <= S_DB;
                S_DB: state_reg <= S_DC;
                S_DC: state_reg <= S_DD;
                S_DD:
                begin
                    // first projection must be negative here
                    if (!status.acc_neg)
                    begin
                        hit_reg   <= 1'b0;
                        state_reg <= state_done;
                    end
                    else
                        state_reg <= S_DE;
                end
                S_DE: state_reg <= S_DF;
                S_DF:
                begin
                    hit_reg   <= acc_pos;
                    state_reg <= state_done;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        intersects_reg <= hit_reg;
                        have_prev_reg  <= 1'b0;
                        hit_reg        <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/polyline_circle_intersect.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_circle_intersect: streamed polygon edge / circle intersection test
// Vertices arrive one per transaction; each edge from the previous vertex is
// tested against the configured circle until one intersects, and one flag is
// returned after the vertex marked last.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     vertex_x, vertex_y,
//                                               first_vertex, last_vertex
//   out      output     out_valid / out_ready   intersects
//   cfg      input      cfg_write               cfg_index, cfg_data
//
// A vertex that closes no edge leaves the block idle, or goes to the result
// step when it is the last one. An edge test ends early when an endpoint
// decides it and otherwise runs the axis-aligned or general line test; the
// single shared digit multiplier issues one product per cycle in its product steps.
// Reset clears the polygon state, the circle registers and the result.
// The result register frees the input side; a stalled result only holds
// back the next last vertex at its result step.
// ----------------------------------------------------------------------------
module polyline_circle_intersect #(
    parameter int COORD_WIDTH = pci_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [pci_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [COORD_WIDTH-1:0]           cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [COORD_WIDTH-1:0]    vertex_x,
    input  logic signed [COORD_WIDTH-1:0]    vertex_y,
    input  logic                             first_vertex,
    input  logic                             last_vertex,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             intersects
);

    pci_pkg::dp_cmd_t    cmd;
    pci_pkg::dp_status_t status;

    // Sequencer
    pci_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .first_vertex (first_vertex),
        .last_vertex  (last_vertex),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .intersects   (intersects),
        .cmd          (cmd),
        .status       (status)
    );

    // Arithmetic
    pci_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .vertex_x  (vertex_x),
        .vertex_y  (vertex_y),
        .cmd       (cmd),
        .status    (status)
    );

    // No product is issued while the block waits for a transaction
    a_no_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && cmd.mul_en))
        else $error("multiplier issued while idle");

    // A taken last vertex always leaves idle to finish the polygon
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_vertex) |=> !in_ready)
        else $error("last vertex did not start result step");

    // Intermediate stores never coincide with a vertex load
    a_store_load: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.act != pci_pkg::ACT_NONE) |-> !cmd.load)
        else $error("store action during vertex load");

    // A new result appears only from the busy result step
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result raised while idle");

endmodule
`default_nettype wire
